### design/alm_pkg.sv
package alm_pkg;

  // Operation codes of an input transaction
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Message codes of a result transaction
  localparam logic [2:0] CODE_FRONT      = 3'd0;
  localparam logic [2:0] CODE_REAR       = 3'd1;
  localparam logic [2:0] CODE_DOOR_FRONT = 3'd2;
  localparam logic [2:0] CODE_DOOR_REAR  = 3'd3;
  localparam logic [2:0] CODE_ENDED      = 3'd4;
  localparam logic [2:0] CODE_TIMEOUT    = 3'd5;
  localparam logic [2:0] CODE_NONE       = 3'd7;

  // Register indexes (byte address divided by four)
  localparam logic [2:0] REG_TIMEOUT     = 3'd0;
  localparam logic [2:0] REG_FRONT       = 3'd1;
  localparam logic [2:0] REG_REAR        = 3'd2;
  localparam logic [2:0] REG_DOOR_FRONT  = 3'd3;
  localparam logic [2:0] REG_DOOR_REAR   = 3'd4;
  localparam logic [2:0] REG_HEARTBEAT   = 3'd5;

  // Register reset values
  localparam logic [15:0] TIMEOUT_RESET    = 16'd5000;
  localparam logic [31:0] FRONT_RESET      = 32'h414C564F;
  localparam logic [31:0] REAR_RESET       = 32'h414C4849;
  localparam logic [31:0] DOOR_FRONT_RESET = 32'h5441564F;
  localparam logic [31:0] DOOR_REAR_RESET  = 32'h54414849;
  localparam logic [31:0] HEARTBEAT_RESET  = 32'h6E697878;

  // Alarm timer
  localparam int unsigned MS_PER_SECOND = 1000;
  localparam logic [10:0] MS_WRAP       = 11'(MS_PER_SECOND);
  localparam logic [22:0] SECONDS_MAX   = 23'h7FFFFF;

  localparam int unsigned ADDR_W = 5;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  message_code;
    logic [31:0] timestamp_ms;
    logic [22:0] duration_s;
  } out_item_t;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [31:0] alarm_word_front;
    logic [31:0] alarm_word_rear;
    logic [31:0] door_word_front;
    logic [31:0] door_word_rear;
    logic [31:0] heartbeat_word;
  } cfg_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] code;
  } match_t;

endpackage

### design/alm_cfg.sv
module alm_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [alm_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output alm_pkg::cfg_t                cfg
);

  logic [2:0] index;
  logic       wr_en;

  assign pready = 1'b1;
  assign index  = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;

  // Write registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ms       <= alm_pkg::TIMEOUT_RESET;
      cfg.alarm_word_front <= alm_pkg::FRONT_RESET;
      cfg.alarm_word_rear  <= alm_pkg::REAR_RESET;
      cfg.door_word_front  <= alm_pkg::DOOR_FRONT_RESET;
      cfg.door_word_rear   <= alm_pkg::DOOR_REAR_RESET;
      cfg.heartbeat_word   <= alm_pkg::HEARTBEAT_RESET;
    end else if (wr_en) begin
      case (index)
        alm_pkg::REG_TIMEOUT:    cfg.timeout_ms       <= pwdata[15:0];
        alm_pkg::REG_FRONT:      cfg.alarm_word_front <= pwdata;
        alm_pkg::REG_REAR:       cfg.alarm_word_rear  <= pwdata;
        alm_pkg::REG_DOOR_FRONT: cfg.door_word_front  <= pwdata;
        alm_pkg::REG_DOOR_REAR:  cfg.door_word_rear   <= pwdata;
        alm_pkg::REG_HEARTBEAT:  cfg.heartbeat_word   <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (index)
      alm_pkg::REG_TIMEOUT:    prdata = {16'd0, cfg.timeout_ms};
      alm_pkg::REG_FRONT:      prdata = cfg.alarm_word_front;
      alm_pkg::REG_REAR:       prdata = cfg.alarm_word_rear;
      alm_pkg::REG_DOOR_FRONT: prdata = cfg.door_word_front;
      alm_pkg::REG_DOOR_REAR:  prdata = cfg.door_word_rear;
      alm_pkg::REG_HEARTBEAT:  prdata = cfg.heartbeat_word;
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

### design/alm_match.sv
module alm_match (
  input  logic [31:0]    word,
  input  logic           window_full,
  input  alm_pkg::cfg_t  cfg,
  output alm_pkg::match_t match
);

  // Compare the window against every word; heartbeat has priority
  always_comb begin
    match.hit  = window_full;
    match.code = alm_pkg::CODE_NONE;
    if (word == cfg.heartbeat_word) begin
      match.code = alm_pkg::CODE_ENDED;
    end else if (word == cfg.alarm_word_front) begin
      match.code = alm_pkg::CODE_FRONT;
    end else if (word == cfg.alarm_word_rear) begin
      match.code = alm_pkg::CODE_REAR;
    end else if (word == cfg.door_word_front) begin
      match.code = alm_pkg::CODE_DOOR_FRONT;
    end else if (word == cfg.door_word_rear) begin
      match.code = alm_pkg::CODE_DOOR_REAR;
    end else begin
      match.hit = 1'b0;
    end
  end

endmodule

### design/alm_core.sv
module alm_core (
  input  logic               clk,
  input  logic               rst,
  input  alm_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  alm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output alm_pkg::out_item_t out_data
);

  // Input register
  logic              s1_valid;
  alm_pkg::in_item_t s1_item;
  logic              advance;

  // Monitor state
  logic [23:0] window_bytes, window_bytes_next;
  logic [1:0]  window_fill, window_fill_next;
  logic [31:0] now_ms, now_ms_next;
  logic [15:0] since_valid_ms, since_valid_ms_next;
  logic        timeout_reported, timeout_reported_next;
  logic        alarm_running, alarm_running_next;
  logic [9:0]  alarm_ms_part, alarm_ms_part_next;
  logic [22:0] alarm_seconds, alarm_seconds_next;
  logic [2:0]  last_sent_code, last_sent_code_next;

  // Report candidate
  logic        report;
  logic [2:0]  report_code;
  logic [22:0] report_dur;
  logic        emit;

  logic [31:0]      word;
  logic [10:0]      ms_inc;
  alm_pkg::match_t  match;

  // Process the held transaction when the result register is free or drains
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  assign word   = {window_bytes, s1_item.rx_byte};
  assign ms_inc = {1'b0, alarm_ms_part} + 11'd1;

  alm_match u_match (
    .word        (word),
    .window_full (window_fill == 2'd3),
    .cfg         (cfg),
    .match       (match)
  );

  // Next state of the monitor for the held transaction
  always_comb begin
    window_bytes_next     = window_bytes;
    window_fill_next      = window_fill;
    now_ms_next           = now_ms;
    since_valid_ms_next   = since_valid_ms;
    timeout_reported_next = timeout_reported;
    alarm_running_next    = alarm_running;
    alarm_ms_part_next    = alarm_ms_part;
    alarm_seconds_next    = alarm_seconds;
    report                = 1'b0;
    report_code           = alm_pkg::CODE_NONE;
    report_dur            = 23'd0;

    if (s1_item.operation == alm_pkg::OP_TICK) begin
      now_ms_next = now_ms + 32'd1;
      // advance the alarm timer
      if (alarm_running) begin
        if (ms_inc >= alm_pkg::MS_WRAP) begin
          alarm_ms_part_next = 10'd0;
          if (alarm_seconds < alm_pkg::SECONDS_MAX) begin
            alarm_seconds_next = alarm_seconds + 23'd1;
          end
        end else begin
          alarm_ms_part_next = ms_inc[9:0];
        end
      end
      // watchdog
      if (since_valid_ms < cfg.timeout_ms) begin
        since_valid_ms_next = since_valid_ms + 16'd1;
      end else if (!timeout_reported) begin
        timeout_reported_next = 1'b1;
        report                = 1'b1;
        report_code           = alm_pkg::CODE_TIMEOUT;
      end
    end else if (!match.hit) begin
      // shift the byte into the window
      window_bytes_next = word[23:0];
      if (window_fill != 2'd3) begin
        window_fill_next = window_fill + 2'd1;
      end
    end else begin
      // clear the window and refresh the watchdog on a valid word
      window_bytes_next     = 24'd0;
      window_fill_next      = 2'd0;
      since_valid_ms_next   = 16'd0;
      timeout_reported_next = 1'b0;
      if (match.code == alm_pkg::CODE_ENDED) begin
        if (alarm_running) begin
          alarm_running_next = 1'b0;
          report             = 1'b1;
          report_code        = alm_pkg::CODE_ENDED;
          report_dur         = alarm_seconds;
        end
      end else begin
        if (!alarm_running) begin
          alarm_running_next = 1'b1;
          alarm_ms_part_next = 10'd0;
          alarm_seconds_next = 23'd0;
        end
        report      = 1'b1;
        report_code = match.code;
      end
    end

    // drop a repeat of the last code without duration
    emit = report && !(report_code == last_sent_code && report_dur == 23'd0);
    last_sent_code_next = emit ? report_code : last_sent_code;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item <= in_data;
    end
  end

  // Monitor state update
  always_ff @(posedge clk) begin
    if (rst) begin
      window_bytes     <= 24'd0;
      window_fill      <= 2'd0;
      now_ms           <= 32'd0;
      since_valid_ms   <= 16'd0;
      timeout_reported <= 1'b0;
      alarm_running    <= 1'b0;
      alarm_ms_part    <= 10'd0;
      alarm_seconds    <= 23'd0;
      last_sent_code   <= alm_pkg::CODE_NONE;
    end else if (s1_valid && advance) begin
      window_bytes     <= window_bytes_next;
      window_fill      <= window_fill_next;
      now_ms           <= now_ms_next;
      since_valid_ms   <= since_valid_ms_next;
      timeout_reported <= timeout_reported_next;
      alarm_running    <= alarm_running_next;
      alarm_ms_part    <= alarm_ms_part_next;
      alarm_seconds    <= alarm_seconds_next;
      last_sent_code   <= last_sent_code_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && emit) begin
      out_data.message_code <= report_code;
      out_data.timestamp_ms <= now_ms_next;
      out_data.duration_s   <= report_dur;
    end
  end

  // A pending result is always the last code sent
  a_last_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last_sent_code == out_data.message_code)
    else $error("pending result code differs from last sent code");

  // Only an alarm-ended report carries a duration
  a_dur_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.message_code != alm_pkg::CODE_ENDED |-> out_data.duration_s == 23'd0)
    else $error("nonzero duration on a report other than alarm ended");

  // Millisecond part of the alarm timer stays below one second
  a_ms_part: assert property (@(posedge clk) disable iff (rst)
    {1'b0, alarm_ms_part} < alm_pkg::MS_WRAP)
    else $error("alarm millisecond part out of range");

  // A pending timeout report implies the silence is still flagged
  a_timeout_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.message_code == alm_pkg::CODE_TIMEOUT |-> timeout_reported)
    else $error("timeout report pending without timeout flag");

endmodule

### design/alarm_link_monitor.sv
// Alarm link monitor. Input transactions are either a received radio byte or a
// one-millisecond tick; the block keeps a four-byte window over the bytes, a
// millisecond time base, a link watchdog and an alarm timer, and emits at most
// one report per input transaction (alarm code, alarm ended with its length in
// seconds, or link timeout). One transaction is taken every clock cycle unless the
// input is stalled: it is captured in the input register, processed in a single pass
// of compare and counter logic, and its report, if any, is loaded into the output
// register once that register is free or drains. Backpressure on the output stalls
// the input only while the output register holds an untaken report. Match words and
// the timeout are set through the APB port and take effect on the next transaction.
module alarm_link_monitor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  alm_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output alm_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [alm_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  alm_pkg::cfg_t cfg;

  alm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  alm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### tb/alarm_link_monitor_test.sv
module alarm_link_monitor_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Addresses past the last register; writes there must change nothing
  localparam logic [2:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_RESULT} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               op;
    logic [7:0]         rx;
    alm_pkg::out_item_t rep;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  alm_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  alm_pkg::out_item_t out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [alm_pkg::ADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  alarm_link_monitor dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Monitor state as the block should hold it
  alm_pkg::cfg_t link_cfg;
  logic [23:0]   win_bytes;
  int            win_fill;
  logic [31:0]   clock_ms;
  logic [15:0]   silence_ms;
  bit            timeout_flagged;
  bit            alarm_on;
  logic [9:0]    alarm_ms;
  logic [22:0]   alarm_sec;
  logic [2:0]    last_code;

  alm_pkg::out_item_t pending_reports[$];
  stim_row_t          dir_rows[$];

  int error_count;
  int items_sent;
  int ticks_sent;
  int reports_checked;
  int input_stall_cycles;
  int reports_by_code[8];
  int burst_left;
  bit steady;
  int hold_cycles;
  int pattern_left;
  int pattern_pct;

  task automatic report_error(input string what);
    error_count++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  function automatic void reset_monitor_state();
    link_cfg.timeout_ms       = alm_pkg::TIMEOUT_RESET;
    link_cfg.alarm_word_front = alm_pkg::FRONT_RESET;
    link_cfg.alarm_word_rear  = alm_pkg::REAR_RESET;
    link_cfg.door_word_front  = alm_pkg::DOOR_FRONT_RESET;
    link_cfg.door_word_rear   = alm_pkg::DOOR_REAR_RESET;
    link_cfg.heartbeat_word   = alm_pkg::HEARTBEAT_RESET;
    win_bytes       = '0;
    win_fill        = 0;
    clock_ms        = '0;
    silence_ms      = '0;
    timeout_flagged = 1'b0;
    alarm_on        = 1'b0;
    alarm_ms        = '0;
    alarm_sec       = '0;
    last_code       = alm_pkg::CODE_NONE;
  endfunction

  // Drop a repeat of the last code unless it carries a duration
  function automatic bit make_report(input logic [2:0] code, input logic [22:0] dur,
                                     output alm_pkg::out_item_t rep);
    rep = '0;
    if (code == last_code && dur == '0) return 1'b0;
    last_code = code;
    rep.message_code = code;
    rep.timestamp_ms = clock_ms;
    rep.duration_s   = dur;
    return 1'b1;
  endfunction

  function automatic bit next_report(input alm_pkg::in_item_t it,
                                     output alm_pkg::out_item_t rep);
    logic [31:0] word;
    logic [2:0]  code;
    bit          hit;
    rep  = '0;
    hit  = 1'b0;
    code = alm_pkg::CODE_NONE;
    if (it.operation == alm_pkg::OP_TICK) begin
      // advance time base, alarm timer, then the silence counter
      clock_ms = clock_ms + 32'd1;
      if (alarm_on) begin
        alarm_ms = alarm_ms + 10'd1;
        if (alarm_ms >= alm_pkg::MS_PER_SECOND) begin
          alarm_ms = '0;
          if (alarm_sec != alm_pkg::SECONDS_MAX) alarm_sec = alarm_sec + 23'd1;
        end
      end
      if (silence_ms < link_cfg.timeout_ms) begin
        silence_ms = silence_ms + 16'd1;
        return 1'b0;
      end
      if (timeout_flagged) return 1'b0;
      timeout_flagged = 1'b1;
      return make_report(alm_pkg::CODE_TIMEOUT, '0, rep);
    end
    word = {win_bytes, it.rx_byte};
    if (win_fill >= 3) begin
      hit = 1'b1;
      if (word == link_cfg.heartbeat_word) code = alm_pkg::CODE_ENDED;
      else if (word == link_cfg.alarm_word_front) code = alm_pkg::CODE_FRONT;
      else if (word == link_cfg.alarm_word_rear) code = alm_pkg::CODE_REAR;
      else if (word == link_cfg.door_word_front) code = alm_pkg::CODE_DOOR_FRONT;
      else if (word == link_cfg.door_word_rear) code = alm_pkg::CODE_DOOR_REAR;
      else hit = 1'b0;
    end
    if (!hit) begin
      win_bytes = word[23:0];
      if (win_fill < 3) win_fill++;
      return 1'b0;
    end
    // a match empties the window and refreshes the watchdog
    win_bytes       = '0;
    win_fill        = 0;
    silence_ms      = '0;
    timeout_flagged = 1'b0;
    if (code == alm_pkg::CODE_ENDED) begin
      if (!alarm_on) return 1'b0;
      alarm_on = 1'b0;
      return make_report(alm_pkg::CODE_ENDED, alarm_sec, rep);
    end
    if (!alarm_on) begin
      alarm_on  = 1'b1;
      alarm_ms  = '0;
      alarm_sec = '0;
    end
    return make_report(code, '0, rep);
  endfunction

  function automatic logic [31:0] reg_value(input logic [2:0] idx);
    case (idx)
      alm_pkg::REG_TIMEOUT:     return {16'd0, link_cfg.timeout_ms};
      alm_pkg::REG_FRONT:       return link_cfg.alarm_word_front;
      alm_pkg::REG_REAR:        return link_cfg.alarm_word_rear;
      alm_pkg::REG_DOOR_FRONT:  return link_cfg.door_word_front;
      alm_pkg::REG_DOOR_REAR:   return link_cfg.door_word_rear;
      alm_pkg::REG_HEARTBEAT:   return link_cfg.heartbeat_word;
      default:                  return '0;
    endcase
  endfunction

  // One APB transfer: setup, access, then idle
  task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] data,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] unused;
    apb_access(1'b1, idx, value, unused);
    case (idx)
      alm_pkg::REG_TIMEOUT:     link_cfg.timeout_ms       = value[15:0];
      alm_pkg::REG_FRONT:       link_cfg.alarm_word_front = value;
      alm_pkg::REG_REAR:        link_cfg.alarm_word_rear  = value;
      alm_pkg::REG_DOOR_FRONT:  link_cfg.door_word_front  = value;
      alm_pkg::REG_DOOR_REAR:   link_cfg.door_word_rear   = value;
      alm_pkg::REG_HEARTBEAT:   link_cfg.heartbeat_word   = value;
      default:                  ;
    endcase
  endtask

  task automatic check_registers();
    logic [31:0] rd;
    logic [31:0] mask;
    for (int i = alm_pkg::REG_TIMEOUT; i <= alm_pkg::REG_HEARTBEAT; i++) begin
      apb_access(1'b0, 3'(i), '0, rd);
      mask = (3'(i) == alm_pkg::REG_TIMEOUT) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
      if ((rd & mask) != reg_value(3'(i)))
        report_error($sformatf("register %0d reads %h, want %h", i, rd, reg_value(3'(i))));
    end
  endtask

  // Hand one transaction to the block and record what it should produce
  task automatic offer(input alm_pkg::in_item_t it, input row_kind_t kind,
                       input alm_pkg::out_item_t typed);
    alm_pkg::out_item_t rep;
    bit                 has;
    int                 gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(posedge clk);
      if (in_stall) input_stall_cycles++;
    end while (in_stall);
    has = next_report(it, rep);
    case (kind)
      ROW_PREDICT: if (has) pending_reports.push_back(rep);
      ROW_RESULT:  pending_reports.push_back(typed);
      default:     ;
    endcase
    items_sent++;
    if (it.operation == alm_pkg::OP_TICK) ticks_sent++;
    // pace the sender in bursts with idle gaps between them
    if (!steady) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    alm_pkg::in_item_t it;
    it.operation = alm_pkg::OP_BYTE;
    it.rx_byte   = b;
    offer(it, ROW_PREDICT, '0);
  endtask

  task automatic send_tick();
    alm_pkg::in_item_t it;
    it.operation = alm_pkg::OP_TICK;
    it.rx_byte   = 8'($urandom_range(255));
    offer(it, ROW_PREDICT, '0);
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) send_byte(w[31-8*i -: 8]);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(4))
      0:       return link_cfg.heartbeat_word;
      1:       return link_cfg.alarm_word_front;
      2:       return link_cfg.alarm_word_rear;
      3:       return link_cfg.door_word_front;
      default: return link_cfg.door_word_rear;
    endcase
  endfunction

  // Whole words, broken words, runs of ticks and random noise bytes, in random order
  task automatic run_random(input int count);
    int          stop_at;
    int          pick;
    int          len;
    int          cap;
    logic [31:0] w;
    stop_at = items_sent + count;
    steady  = ($urandom_range(3) == 0);
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_word(pick_word());
      end else if (pick < 55) begin
        w   = pick_word();
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) send_byte(w[31-8*i -: 8]);
        send_byte(8'($urandom_range(255)));
      end else if (pick < 80) begin
        cap = 2 * int'(link_cfg.timeout_ms) + 2;
        if (cap > 40) cap = 40;
        len = $urandom_range(1, cap);
        repeat (len) send_tick();
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // Idle the input and wait until every report is out and the pipeline is empty
  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic randomize_config();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) write_reg(alm_pkg::REG_TIMEOUT, 32'd1);
    else if (sel == 1) write_reg(alm_pkg::REG_TIMEOUT, 32'($urandom_range(100, 400)));
    else write_reg(alm_pkg::REG_TIMEOUT, 32'($urandom_range(2, 30)));
    write_reg(alm_pkg::REG_FRONT, $urandom);
    write_reg(alm_pkg::REG_REAR, $urandom);
    write_reg(alm_pkg::REG_DOOR_FRONT, $urandom);
    write_reg(alm_pkg::REG_DOOR_REAR, $urandom);
    write_reg(alm_pkg::REG_HEARTBEAT, $urandom);
    write_reg(($urandom_range(1) == 0) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI, $urandom);
  endtask

  function automatic void add_row(input row_kind_t kind, input logic op, input logic [7:0] rx,
                                  input logic [2:0] code, input logic [31:0] ts);
    stim_row_t r;
    r.kind             = kind;
    r.op               = op;
    r.rx               = rx;
    r.rep.message_code = code;
    r.rep.timestamp_ms = ts;
    r.rep.duration_s   = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_word(input logic [31:0] w, input row_kind_t last_kind,
                                   input logic [2:0] code, input logic [31:0] ts);
    for (int i = 0; i < 3; i++) begin
      add_row(ROW_NONE, alm_pkg::OP_BYTE, w[31-8*i -: 8], alm_pkg::CODE_NONE, '0);
    end
    add_row(last_kind, alm_pkg::OP_BYTE, w[7:0], code, ts);
  endfunction

  // Compare each accepted report with the oldest one expected
  always @(posedge clk) begin : check_reports
    alm_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        report_error($sformatf("unexpected report code %0d ts %0d dur %0d",
                               out_data.message_code, out_data.timestamp_ms,
                               out_data.duration_s));
      end else begin
        want = pending_reports.pop_front();
        if (out_data.message_code !== want.message_code)
          report_error($sformatf("message_code %0d, want %0d",
                                 out_data.message_code, want.message_code));
        if (out_data.timestamp_ms !== want.timestamp_ms)
          report_error($sformatf("timestamp_ms %0d, want %0d (code %0d)",
                                 out_data.timestamp_ms, want.timestamp_ms, want.message_code));
        if (out_data.duration_s !== want.duration_s)
          report_error($sformatf("duration_s %0d, want %0d (code %0d)",
                                 out_data.duration_s, want.duration_s, want.message_code));
        reports_checked++;
        reports_by_code[want.message_code]++;
      end
    end
  end

  // Output side: random stall pattern, with a long hold-off when requested
  initial begin
    out_stall    = 1'b0;
    pattern_left = 0;
    pattern_pct  = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        if (pattern_left == 0) begin
          case ($urandom_range(4))
            0, 1:    pattern_pct = 0;
            2:       pattern_pct = 25;
            3:       pattern_pct = 60;
            default: pattern_pct = 90;
          endcase
          pattern_left = $urandom_range(16, 128);
        end
        pattern_left--;
        out_stall <= ($urandom_range(99) < pattern_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("alarm_link_monitor: mismatch");
    $finish;
  end

  initial begin
    alm_pkg::in_item_t it;
    int                n;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    hold_cycles = 0;
    burst_left  = 4;
    steady      = 1'b0;
    reset_monitor_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values, then the directed table under the reset configuration
    check_registers();
    add_row(ROW_NONE, alm_pkg::OP_BYTE, 8'hFF, alm_pkg::CODE_NONE, '0);
    add_row(ROW_NONE, alm_pkg::OP_BYTE, 8'h00, alm_pkg::CODE_NONE, '0);
    add_row(ROW_NONE, alm_pkg::OP_TICK, 8'hFF, alm_pkg::CODE_NONE, '0);
    add_word(alm_pkg::HEARTBEAT_RESET, ROW_NONE, alm_pkg::CODE_NONE, '0);
    add_word(alm_pkg::FRONT_RESET, ROW_RESULT, alm_pkg::CODE_FRONT, 32'd1);
    add_word(alm_pkg::REAR_RESET, ROW_RESULT, alm_pkg::CODE_REAR, 32'd1);
    add_row(ROW_PREDICT, alm_pkg::OP_TICK, 8'h00, alm_pkg::CODE_NONE, '0);
    add_word(alm_pkg::DOOR_FRONT_RESET, ROW_RESULT, alm_pkg::CODE_DOOR_FRONT, 32'd2);
    add_word(alm_pkg::DOOR_REAR_RESET, ROW_RESULT, alm_pkg::CODE_DOOR_REAR, 32'd2);
    add_word(alm_pkg::HEARTBEAT_RESET, ROW_RESULT, alm_pkg::CODE_ENDED, 32'd2);
    foreach (dir_rows[i]) begin
      it.operation = dir_rows[i].op;
      it.rx_byte   = dir_rows[i].rx;
      offer(it, dir_rows[i].kind, dir_rows[i].rep);
    end
    settle();

    // Zero timeout: report on the first tick after a valid word
    write_reg(alm_pkg::REG_TIMEOUT, 32'd0);
    check_registers();
    run_random(20);
    settle();

    // Timeout of one and extreme words; unmapped addresses must be ignored
    write_reg(alm_pkg::REG_TIMEOUT, 32'd1);
    write_reg(alm_pkg::REG_FRONT, 32'h0000_0000);
    write_reg(alm_pkg::REG_REAR, 32'hFFFF_FFFF);
    write_reg(REG_UNMAPPED_LO, $urandom);
    write_reg(REG_UNMAPPED_HI, $urandom);
    check_registers();
    run_random(30);
    settle();

    // All five words equal: the heartbeat takes priority
    n = $urandom;
    write_reg(alm_pkg::REG_TIMEOUT, 32'd8);
    write_reg(alm_pkg::REG_FRONT, n);
    write_reg(alm_pkg::REG_REAR, n);
    write_reg(alm_pkg::REG_DOOR_FRONT, n);
    write_reg(alm_pkg::REG_DOOR_REAR, n);
    write_reg(alm_pkg::REG_HEARTBEAT, n);
    check_registers();
    run_random(20);
    settle();

    // Alarm words equal, heartbeat distinct: front takes priority
    write_reg(alm_pkg::REG_HEARTBEAT, ~32'(n));
    run_random(20);
    settle();

    // Largest timeout and an alarm lasting at least a second
    write_reg(alm_pkg::REG_TIMEOUT, 32'hFFFF);
    check_registers();
    steady = 1'b1;
    send_word(link_cfg.alarm_word_front);
    repeat ($urandom_range(1000, 1020)) send_tick();
    send_word(link_cfg.heartbeat_word);
    settle();

    // Hold the output off while alternating alarms keep reports coming
    randomize_config();
    check_registers();
    steady      = 1'b1;
    hold_cycles = 300;
    for (int k = 0; k < 6; k++)
      send_word((k % 2 == 0) ? link_cfg.alarm_word_front : link_cfg.alarm_word_rear);
    settle();

    // Random configurations
    for (int p = 0; p < 2; p++) begin
      randomize_config();
      check_registers();
      run_random(20);
      settle();
    end

    $display("covered: %0d transactions, %0d ticks, %0d reports, %0d input stall cycles",
             items_sent, ticks_sent, reports_checked, input_stall_cycles);
    $display("reports: front %0d rear %0d door front %0d door rear %0d ended %0d timeout %0d",
             reports_by_code[alm_pkg::CODE_FRONT], reports_by_code[alm_pkg::CODE_REAR],
             reports_by_code[alm_pkg::CODE_DOOR_FRONT], reports_by_code[alm_pkg::CODE_DOOR_REAR],
             reports_by_code[alm_pkg::CODE_ENDED], reports_by_code[alm_pkg::CODE_TIMEOUT]);
    if (error_count == 0) begin
      $display("alarm_link_monitor: match");
    end else begin
      $display("alarm_link_monitor: mismatch");
    end
    $finish;
  end

endmodule
